/* hw/rtl/matrix_multiply_transposed_assert.svh */
// assertion macros for the matrix multiply rtl
`ifndef MATRIX_MULTIPLY_TRANSPOSED_ASSERT_SVH
`define MATRIX_MULTIPLY_TRANSPOSED_ASSERT_SVH

// same-cycle implication, checked only out of reset
`define MMT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked only out of reset
`define MMT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/mmt_pkg.sv */
// types and constants for the matrix multiply block
`timescale 1ns / 1ps

package mmt_pkg;

    localparam int CNT_W = 4;
    localparam int IDX_W = 3;
    localparam int ELEM_W = 32;
    localparam int ACC_W = 64;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    typedef enum logic [1:0] {
        REQ_LOAD_A  = 2'd0,
        REQ_LOAD_B  = 2'd1,
        REQ_COMPUTE = 2'd2
    } req_t;

    typedef enum logic [1:0] {
        CFG_ROW_COUNT   = 2'd0,
        CFG_COL_COUNT   = 2'd1,
        CFG_DEPTH_COUNT = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        req_t                     req_type;
        logic [IDX_W-1:0]         row_index;
        logic [IDX_W-1:0]         depth_index;
        logic signed [ELEM_W-1:0] element_value;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0]        out_row;
        logic [IDX_W-1:0]        out_col;
        logic signed [ACC_W-1:0] product_value;
        logic                    last_item;
    } out_item_t;

    // tag that travels with each pair of elements through the mac
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } mac_ctl_t;

endpackage

/* hw/rtl/mmt_ram.sv */
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module mmt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* hw/rtl/mmt_mac.sv */
// two-stage multiply and saturating accumulate
`timescale 1ns / 1ps

module mmt_mac
    import mmt_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  mac_ctl_t                 ctl,
    input  logic signed [ELEM_W-1:0] a_val,
    input  logic signed [ELEM_W-1:0] b_val,
    output logic signed [ACC_W-1:0]  acc,
    output logic                     done
);

    mac_ctl_t                ctl_reg;
    logic signed [ACC_W-1:0] prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic signed [ACC_W-1:0] base;
    logic signed [ACC_W-1:0] sum;
    logic                    done_reg;
    logic                    ovf;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            ctl_reg  <= ctl;
            done_reg <= ctl_reg.valid & ctl_reg.last;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= a_val * b_val;
        if (ctl_reg.valid)
        begin
            acc_reg <= acc_next;
        end
    end

    // same signs in, different sign out means overflow
    always_comb
    begin
        base     = ctl_reg.first ? '0 : acc_reg;
        sum      = base + prod_reg;
        ovf      = (base[ACC_W-1] == prod_reg[ACC_W-1]) && (sum[ACC_W-1] != base[ACC_W-1]);
        acc_next = ovf ? (base[ACC_W-1] ? ACC_MIN : ACC_MAX) : sum;
    end

    assign acc  = acc_reg;
    assign done = done_reg;

endmodule

/* hw/rtl/matrix_multiply_transposed.sv */
// top level: element stores, compute sequencer and result register
`timescale 1ns / 1ps
`include "matrix_multiply_transposed_assert.svh"

// matrix multiply of A by B transposed, signed Q16.16 in, saturated Q32.32 out.
// in channel (in_valid/in_ready/in_item): an item either loads one element of A
// or B into its store (no result) or starts a compute. a load with a
// row or depth index of MAX_DIM or more is dropped, and so is request code 3.
// a compute emits rows x cols result items on the out channel, row-major, with
// last_item set on the final one. for each result element the sequencer issues
// one store read per depth step to the single multiplier; the sum then passes
// the read, multiply and accumulate registers before it is handed over.
// in_ready is low from the compute item until the last result has been handed
// to the output register; the block then takes new items even if that result
// still waits. when the output register is full and out_ready is low the sequencer
// holds the finished sum and waits, nothing is dropped.
// cfg_we/cfg_index/cfg_data write row, col and depth counts (0 acts as 1,
// above MAX_DIM acts as MAX_DIM); write them only while the block is idle.
// reset sets all counts to 8 (clamped to MAX_DIM) and clears the handshakes;
// store contents are undefined until loaded and are not cleared.
module matrix_multiply_transposed
    import mmt_pkg::*;
#(
    parameter int MAX_DIM = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  in_item_t         in_item,
    output logic             out_valid,
    input  logic             out_ready,
    output out_item_t        out_item,
    input  logic             cfg_we,
    input  cfg_idx_t         cfg_index,
    input  logic [CNT_W-1:0] cfg_data
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CLAMP = (MAX_DIM > 15) ? 15 : MAX_DIM;
    localparam int RST_CNT = (8 > CLAMP) ? CLAMP : 8;
    localparam logic [CNT_W-1:0] CLAMP_C = CLAMP[CNT_W-1:0];
    localparam logic [CNT_W-1:0] RST_LAST = RST_CNT[CNT_W-1:0] - 1'b1;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic [CNT_W-1:0] row_last_reg, col_last_reg, depth_last_reg;
    logic [CNT_W-1:0] cfg_last;
    logic             done_reg, done_next;
    logic             out_valid_reg;
    out_item_t        out_item_reg;
    mac_ctl_t         issue_ctl_reg;

    logic             issue, emit, out_free, last_elem;
    logic             in_fire, in_range, a_we, b_we;
    logic [31:0]      waddr_wide, a_raddr_wide, b_raddr_wide;
    logic [AW-1:0]    waddr, a_raddr, b_raddr;
    logic [ELEM_W-1:0] a_rdata, b_rdata;
    logic signed [ACC_W-1:0] mac_acc;
    logic             mac_done;

    // config: keep the clamped count minus one
    always_comb
    begin
        if (cfg_data == '0)
        begin
            cfg_last = '0;
        end
        else if (cfg_data > CLAMP_C)
        begin
            cfg_last = CLAMP_C - 1'b1;
        end
        else
        begin
            cfg_last = cfg_data - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_last_reg   <= RST_LAST;
            col_last_reg   <= RST_LAST;
            depth_last_reg <= RST_LAST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ROW_COUNT:   row_last_reg   <= cfg_last;
                CFG_COL_COUNT:   col_last_reg   <= cfg_last;
                CFG_DEPTH_COUNT: depth_last_reg <= cfg_last;
                default:         ;
            endcase
        end
    end

    // load path
    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid & in_ready;
    assign in_range = (int'(in_item.row_index) < MAX_DIM)
                      && (int'(in_item.depth_index) < MAX_DIM);
    assign a_we = in_fire && in_range && (in_item.req_type == REQ_LOAD_A);
    assign b_we = in_fire && in_range && (in_item.req_type == REQ_LOAD_B);

    always_comb
    begin
        waddr_wide   = 32'(int'(in_item.row_index) * MAX_DIM + int'(in_item.depth_index));
        a_raddr_wide = 32'(int'(i_reg) * MAX_DIM + int'(k_reg));
        b_raddr_wide = 32'(int'(j_reg) * MAX_DIM + int'(k_reg));
    end

    assign waddr   = waddr_wide[AW-1:0];
    assign a_raddr = a_raddr_wide[AW-1:0];
    assign b_raddr = b_raddr_wide[AW-1:0];

    mmt_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (DEPTH)
    ) u_a_ram (
        .clk   (clk),
        .we    (a_we),
        .waddr (waddr),
        .wdata (in_item.element_value),
        .re    (issue),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    mmt_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (DEPTH)
    ) u_b_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (waddr),
        .wdata (in_item.element_value),
        .re    (issue),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    mmt_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (issue_ctl_reg),
        .a_val (a_rdata),
        .b_val (b_rdata),
        .acc   (mac_acc),
        .done  (mac_done)
    );

    // sequencer
    assign out_free  = !out_valid_reg || out_ready;
    assign last_elem = (i_reg == row_last_reg) && (j_reg == col_last_reg);

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        issue      = 1'b0;
        emit       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && (in_item.req_type == REQ_COMPUTE))
                begin
                    i_next     = '0;
                    j_next     = '0;
                    k_next     = '0;
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                issue = 1'b1;
                if (k_reg == depth_last_reg)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (done_reg && out_free)
                begin
                    emit   = 1'b1;
                    k_next = '0;
                    if (last_elem)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_ISSUE;
                        if (j_reg == col_last_reg)
                        begin
                            j_next = '0;
                            i_next = i_reg + 1'b1;
                        end
                        else
                        begin
                            j_next = j_reg + 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // finished sum waits here until the output register is free
    assign done_next = (done_reg & ~emit) | mac_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            done_reg      <= 1'b0;
            issue_ctl_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg           <= state_next;
            i_reg               <= i_next;
            j_reg               <= j_next;
            k_reg               <= k_next;
            done_reg            <= done_next;
            issue_ctl_reg.valid <= issue;
            issue_ctl_reg.first <= (k_reg == '0);
            issue_ctl_reg.last  <= (k_reg == depth_last_reg);
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_item_reg.out_row       <= i_reg[IDX_W-1:0];
            out_item_reg.out_col       <= j_reg[IDX_W-1:0];
            out_item_reg.product_value <= mac_acc;
            out_item_reg.last_item     <= last_elem;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    `MMT_ASSERT_NOW(a_store_write_idle, a_we || b_we, state_reg == ST_IDLE,
        "store written while a compute is running")
    `MMT_ASSERT_NOW(a_sum_not_lost, mac_done, (state_reg == ST_DRAIN) && !done_reg,
        "dot product finished outside drain or over an unsent sum")
    `MMT_ASSERT_NOW(a_walk_in_range, state_reg == ST_ISSUE,
        (k_reg <= depth_last_reg) && (i_reg <= row_last_reg) && (j_reg <= col_last_reg),
        "sequencer index beyond configured size")
    `MMT_ASSERT_NEXT(a_compute_starts, in_fire && (in_item.req_type == REQ_COMPUTE),
        (state_reg == ST_ISSUE) && (i_reg == '0) && (j_reg == '0) && (k_reg == '0),
        "compute item did not start the walk at the origin")

endmodule

/* bench/matrix_multiply_transposed_tb.sv */
// self-checking testbench for the A times B-transposed matrix multiply block
`timescale 1ns / 1ps

module matrix_multiply_transposed_tb;
    import mmt_pkg::*;

    localparam int MAX_DIM = 8;
    localparam int STORE_SIZE = MAX_DIM * MAX_DIM;
    localparam int ITEM_TARGET = 250;
    localparam int MAX_GAP = 16;
    localparam int SETTLE_CYCLES = 20;
    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int REPORT_LIMIT = 10;
    localparam req_t REQ_UNUSED = req_t'(2'b11);
    localparam logic signed [ELEM_W-1:0] ELEM_MAX = 32'sh7fff_ffff;
    localparam logic signed [ELEM_W-1:0] ELEM_MIN = 32'sh8000_0000;

    // element stores, counts and the queue of pending dot products
    class gemm_scoreboard;
        logic signed [ELEM_W-1:0] a_elems [STORE_SIZE];
        logic signed [ELEM_W-1:0] b_elems [STORE_SIZE];
        bit a_loaded [STORE_SIZE];
        bit b_loaded [STORE_SIZE];
        logic [CNT_W-1:0] counts [3];
        out_item_t pending [$];
        int mismatches;
        int checked;
        int loads;
        int computes;

        function new();
            for (int n = 0; n < STORE_SIZE; n++)
            begin
                a_loaded[n] = 1'b0;
                b_loaded[n] = 1'b0;
            end
            for (int n = 0; n < 3; n++)
                counts[n] = 4'd8;
            mismatches = 0;
            checked = 0;
            loads = 0;
            computes = 0;
        endfunction

        function int span(cfg_idx_t idx);
            int c;
            c = counts[idx];
            if (c < 1)
                return 1;
            if (c > MAX_DIM)
                return MAX_DIM;
            return c;
        endfunction

        function void set_count(cfg_idx_t idx, logic [CNT_W-1:0] value);
            counts[idx] = value;
        endfunction

        function logic signed [ACC_W-1:0] sat_sum(logic signed [ACC_W-1:0] acc,
                                                  logic signed [ACC_W-1:0] term);
            logic [ACC_W:0] wide;
            wide = {acc[ACC_W-1], acc} + {term[ACC_W-1], term};
            if (wide[ACC_W] != wide[ACC_W-1])
                return wide[ACC_W] ? ACC_MIN : ACC_MAX;
            return wide[ACC_W-1:0];
        endfunction

        function void note_input(in_item_t item);
            int nr;
            int nc;
            int nd;
            int addr;
            logic signed [ACC_W-1:0] acc;
            logic signed [ACC_W-1:0] ea;
            logic signed [ACC_W-1:0] eb;
            out_item_t res;
            addr = item.row_index * MAX_DIM + item.depth_index;
            case (item.req_type)
                REQ_LOAD_A:
                begin
                    a_elems[addr] = item.element_value;
                    a_loaded[addr] = 1'b1;
                    loads++;
                end
                REQ_LOAD_B:
                begin
                    b_elems[addr] = item.element_value;
                    b_loaded[addr] = 1'b1;
                    loads++;
                end
                REQ_COMPUTE:
                begin
                    nr = span(CFG_ROW_COUNT);
                    nc = span(CFG_COL_COUNT);
                    nd = span(CFG_DEPTH_COUNT);
                    computes++;
                    for (int i = 0; i < nr; i++)
                        for (int j = 0; j < nc; j++)
                        begin
                            acc = '0;
                            for (int k = 0; k < nd; k++)
                            begin
                                ea = a_elems[i * MAX_DIM + k];
                                eb = b_elems[j * MAX_DIM + k];
                                acc = sat_sum(acc, ea * eb);
                            end
                            res.out_row = IDX_W'(i);
                            res.out_col = IDX_W'(j);
                            res.product_value = acc;
                            res.last_item = (i == nr - 1) && (j == nc - 1);
                            pending.push_back(res);
                        end
                end
                default:
                    ;
            endcase
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            checked++;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result item: row %0d col %0d value %0d last %0b",
                             got.out_row, got.out_col, $signed(got.product_value),
                             got.last_item);
                return;
            end
            want = pending.pop_front();
            if (got.out_row != want.out_row || got.out_col != want.out_col ||
                got.product_value != want.product_value || got.last_item != want.last_item)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("mismatch: expected row %0d col %0d value %0d last %0b, got row %0d col %0d value %0d last %0b",
                             want.out_row, want.out_col, $signed(want.product_value),
                             want.last_item, got.out_row, got.out_col,
                             $signed(got.product_value), got.last_item);
            end
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    in_item_t         in_item;
    logic             out_valid;
    logic             out_ready;
    out_item_t        out_item;
    logic             cfg_we;
    cfg_idx_t         cfg_index;
    logic [CNT_W-1:0] cfg_data;

    gemm_scoreboard sb;
    bit tx_steady;
    bit rx_steady;
    int items_sent;
    int config_writes;
    int cycle_count;

    matrix_multiply_transposed #(
        .MAX_DIM(MAX_DIM)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_item(in_item),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_item(out_item),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic int draw_gap(bit steady);
        return steady ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    function automatic logic signed [ELEM_W-1:0] draw_element();
        case ($urandom_range(0, 9))
            0: return ELEM_MAX;
            1: return ELEM_MIN;
            2: return '0;
            3, 4: return ELEM_W'((int'($urandom_range(0, 16)) - 8) * 65536);
            default: return $urandom;
        endcase
    endfunction

    // mostly small sizes, now and then a zero, the maximum or an oversized count
    function automatic logic [CNT_W-1:0] draw_count();
        case ($urandom_range(0, 19))
            0: return 4'd0;
            1: return CNT_W'($urandom_range(9, 15));
            2: return 4'd8;
            3, 4, 5: return CNT_W'($urandom_range(4, 7));
            default: return CNT_W'($urandom_range(1, 3));
        endcase
    endfunction

    task automatic send_item(input req_t kind, input logic [IDX_W-1:0] row,
                             input logic [IDX_W-1:0] depth,
                             input logic signed [ELEM_W-1:0] value);
        int gap;
        in_item_t item;
        gap = draw_gap(tx_steady);
        item.req_type = kind;
        item.row_index = row;
        item.depth_index = depth;
        item.element_value = value;
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_item <= item;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_input(item);
        if (kind != REQ_UNUSED)
            items_sent++;
    endtask

    task automatic send_compute();
        send_item(REQ_COMPUTE, IDX_W'($urandom), IDX_W'($urandom), $urandom);
    endtask

    task automatic release_input();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic apply_counts(input bit [2:0] mask, input logic [CNT_W-1:0] rows,
                                input logic [CNT_W-1:0] cols,
                                input logic [CNT_W-1:0] depth);
        logic [CNT_W-1:0] values [3];
        cfg_idx_t idx;
        values[0] = rows;
        values[1] = cols;
        values[2] = depth;
        for (int n = 0; n < 3; n++)
        begin
            if (mask[n])
            begin
                idx = cfg_idx_t'(n);
                @(negedge clk);
                cfg_we <= 1'b1;
                cfg_index <= idx;
                cfg_data <= values[n];
                @(posedge clk);
                sb.set_count(idx, values[n]);
                config_writes++;
            end
        end
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic directed_items();
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        // two min by min terms overflow to the positive limit
        apply_counts(3'b111, 4'd1, 4'd1, 4'd2);
        send_item(REQ_LOAD_A, 3'd0, 3'd0, ELEM_MIN);
        send_item(REQ_LOAD_A, 3'd0, 3'd1, ELEM_MIN);
        send_item(REQ_LOAD_B, 3'd0, 3'd0, ELEM_MIN);
        send_item(REQ_LOAD_B, 3'd0, 3'd1, ELEM_MIN);
        send_compute();
        release_input();
        wait_drained();
        // three min by max terms run past the negative limit
        apply_counts(3'b100, 4'd0, 4'd0, 4'd3);
        send_item(REQ_LOAD_A, 3'd0, 3'd2, ELEM_MIN);
        send_item(REQ_LOAD_B, 3'd0, 3'd0, ELEM_MAX);
        send_item(REQ_LOAD_B, 3'd0, 3'd1, ELEM_MAX);
        send_item(REQ_LOAD_B, 3'd0, 3'd2, ELEM_MAX);
        send_compute();
        release_input();
        wait_drained();
        // zero counts act as one, an oversized count acts as the maximum
        apply_counts(3'b111, 4'd0, 4'd15, 4'd0);
        for (int r = 1; r < MAX_DIM; r++)
            send_item(REQ_LOAD_B, IDX_W'(r), 3'd0, (r % 2) ? ELEM_MAX : ELEM_MIN);
        send_item(REQ_UNUSED, 3'd7, 3'd7, ELEM_MAX);
        send_item(REQ_LOAD_A, 3'd7, 3'd7, ELEM_MAX);
        send_compute();
    endtask

    task automatic random_phase();
        int nr;
        int nc;
        int nd;
        bit refresh;
        bit [2:0] mask;
        req_t kind;
        release_input();
        wait_drained();
        tx_steady = ($urandom_range(0, 3) == 0);
        rx_steady = ($urandom_range(0, 3) == 0);
        mask = 3'($urandom);
        if (mask != 0)
            apply_counts(mask, draw_count(), draw_count(), draw_count());
        nr = sb.span(CFG_ROW_COUNT);
        nc = sb.span(CFG_COL_COUNT);
        nd = sb.span(CFG_DEPTH_COUNT);
        refresh = ($urandom_range(0, 2) == 0);
        // every entry the compute reads must have been loaded at some point
        for (int i = 0; i < nr; i++)
            for (int k = 0; k < nd; k++)
                if (refresh || !sb.a_loaded[i * MAX_DIM + k])
                    send_item(REQ_LOAD_A, IDX_W'(i), IDX_W'(k), draw_element());
        for (int j = 0; j < nc; j++)
            for (int k = 0; k < nd; k++)
                if (refresh || !sb.b_loaded[j * MAX_DIM + k])
                    send_item(REQ_LOAD_B, IDX_W'(j), IDX_W'(k), draw_element());
        repeat ($urandom_range(1, 4))
        begin
            kind = $urandom_range(0, 1) ? REQ_LOAD_A : REQ_LOAD_B;
            case ($urandom_range(0, 5))
                0: send_item(REQ_UNUSED, IDX_W'($urandom), IDX_W'($urandom), $urandom);
                1: send_item(kind, IDX_W'($urandom), IDX_W'($urandom), draw_element());
                default:
                    send_item(kind,
                              IDX_W'($urandom_range(0, (kind == REQ_LOAD_A ? nr : nc) - 1)),
                              IDX_W'($urandom_range(0, nd - 1)), draw_element());
            endcase
        end
        send_compute();
        if ($urandom_range(0, 3) == 0)
            send_compute();
    endtask

    // result side: random stall before each item, steady stretches in some phases
    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = draw_gap(rx_steady);
            repeat (stall)
            begin
                @(negedge clk);
                out_ready <= 1'b0;
            end
            @(negedge clk);
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            sb.check_result(out_item);
        end
    end

    initial
    begin
        int random_start;
        sb = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_ROW_COUNT;
        cfg_data = '0;
        items_sent = 0;
        config_writes = 0;
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        repeat (8)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        directed_items();
        random_start = items_sent;
        while (items_sent - random_start < ITEM_TARGET)
            random_phase();
        release_input();
        wait_drained();

        if (sb.pending.size() != 0)
            $display("%0d expected result items never arrived", sb.pending.size());
        $display("sent %0d load and compute items: %0d loads, %0d computes, %0d count writes",
                 items_sent, sb.loads, sb.computes, config_writes);
        $display("checked %0d result items, %0d mismatches", sb.checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/mmt_pkg.sv
hw/rtl/mmt_ram.sv
hw/rtl/mmt_mac.sv
hw/rtl/matrix_multiply_transposed.sv
bench/matrix_multiply_transposed_tb.sv
